/* hw/rtl/sst_pkg.sv */
package sst_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int RINGS = 3;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] SYS_UNSUP = 2'd3;

  typedef enum logic [2:0] {
    ST_FOUND,
    ST_NEW,
    ST_EVICT,
    ST_BAD_SYS,
    ST_UNKNOWN
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [3:0]  slot;
    logic [7:0]  evicted;
  } res_t;

endpackage

/* hw/rtl/sst_ram.sv */
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sst_ctrl.sv */
module sst_ctrl #(
  parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          op,
  input  logic [1:0]                    sys,
  input  logic [7:0]                    sat,
  output logic                          busy,
  output sst_pkg::res_t                 res,
  output logic                          ram_we,
  output logic [$clog2(3*SLOTS)-1:0]    ram_waddr,
  output logic [7:0]                    ram_wdata,
  output logic [$clog2(3*SLOTS)-1:0]    ram_raddr,
  input  logic [7:0]                    ram_rdata
);

  import sst_pkg::*;

  localparam int AW = $clog2(3 * SLOTS);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SUMW = CW + 1;

  state_t state_r, state_nxt;

  logic          op_r;
  logic [1:0]    ring_r;
  logic [7:0]    sat_r;
  logic [CW-1:0] idx_r;
  logic          pend_r;
  logic          pend_first_r;
  logic [SW-1:0] pend_slot_r;
  logic [7:0]    evict_r;
  logic [SW-1:0] head_r  [RINGS];
  logic [CW-1:0] count_r [RINGS];

  logic [SW-1:0]   cur_head;
  logic [CW-1:0]   cur_count;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] sum_wrap;
  logic [SW-1:0]   phys;
  logic [AW-1:0]   addr;
  logic            issue;
  logic            hit;
  logic            miss;
  logic            full;
  logic            accept;
  logic [SW+3:0]   phys_ext;
  logic [SW+3:0]   pend_ext;

  assign cur_head  = head_r[ring_r];
  assign cur_count = count_r[ring_r];
  assign sum       = SUMW'(cur_head) + SUMW'(idx_r);
  assign sum_wrap  = (sum >= SUMW'(SLOTS)) ? (sum - SUMW'(SLOTS)) : sum;
  assign phys      = sum_wrap[SW-1:0];
  assign addr      = (AW'(ring_r) * AW'(SLOTS)) + AW'(phys);
  assign issue     = idx_r < cur_count;
  assign hit       = pend_r && (ram_rdata == sat_r);
  assign miss      = !issue && !hit;
  assign full      = cur_count == CW'(SLOTS);
  assign accept    = start && (state_r == S_IDLE);
  assign phys_ext  = {4'b0, phys};
  assign pend_ext  = {4'b0, pend_slot_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && (sys != SYS_UNSUP)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_IDLE;
        end else if (miss) begin
          state_nxt = (op_r == OP_LOOKUP) ? S_IDLE : S_WRITE;
        end
      end
      S_WRITE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res       = '0;
    ram_we    = 1'b0;
    ram_raddr = addr;
    ram_waddr = addr;
    ram_wdata = sat_r;
    case (state_r)
      S_IDLE: begin
        if (start && (sys == SYS_UNSUP)) begin
          res.valid  = 1'b1;
          res.status = ST_BAD_SYS;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res.valid  = 1'b1;
          res.status = ST_FOUND;
          res.slot   = pend_ext[3:0];
        end else if (miss && (op_r == OP_LOOKUP)) begin
          res.valid  = 1'b1;
          res.status = ST_UNKNOWN;
        end
      end
      S_WRITE: begin
        ram_we      = 1'b1;
        res.valid   = 1'b1;
        res.status  = full ? ST_EVICT : ST_NEW;
        res.slot    = phys_ext[3:0];
        res.evicted = full ? evict_r : 8'd0;
      end
      default: res = '0;
    endcase
  end

  assign busy = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ring_r       <= 2'd0;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      pend_first_r <= 1'b0;
      for (int i = 0; i < RINGS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (accept && (sys != SYS_UNSUP)) begin
        ring_r <= sys;
        idx_r  <= '0;
        pend_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        pend_r <= issue;
        if (issue) begin
          idx_r        <= idx_r + CW'(1);
          pend_first_r <= idx_r == '0;
        end
      end
      if (state_r == S_WRITE) begin
        if (full) begin
          head_r[ring_r] <= (cur_head == SW'(SLOTS - 1)) ? '0 : cur_head + SW'(1);
        end else begin
          count_r[ring_r] <= cur_count + CW'(1);
        end
      end
    end
  end

  // item payload and scan data
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op;
      sat_r <= sat;
    end
    if ((state_r == S_SCAN) && issue) begin
      pend_slot_r <= phys;
    end
    if ((state_r == S_SCAN) && pend_r && pend_first_r) begin
      evict_r <= ram_rdata;
    end
  end

endmodule

/* hw/rtl/satellite_slot_table_core.sv */
// Slot table for three constellations (GPS, GLONASS, Galileo), SLOTS entries each, kept as
// FIFO-replacement rings in one synchronous RAM. An item is taken when start is high and busy is
// low; its single result appears on the out_ ports for one cycle with out_strobe and cannot be
// held off. An unsupported constellation answers in the cycle after acceptance without raising
// busy. Otherwise the ring is scanned oldest to newest through the RAM read port, one entry per
// cycle: busy covers the scan, which ends on a hit or after the newest entry has been read and
// compared, plus the write state for an insert. The result is on the out_ ports in the first
// cycle that busy is low, and the next item can be taken at the end of that cycle.
module satellite_slot_table_core #(
  parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [1:0] in_constellation,
  input  logic [7:0] in_sat_number,
  output logic       out_strobe,
  output logic [2:0] out_status,
  output logic [3:0] out_slot,
  output logic [7:0] out_evicted_sat
);

  import sst_pkg::*;

  localparam int AW = $clog2(3 * SLOTS);

  res_t          res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          out_strobe_r;
  status_t       out_status_r;
  logic [3:0]    out_slot_r;
  logic [7:0]    out_evicted_r;

  sst_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_operation),
    .sys       (in_constellation),
    .sat       (in_sat_number),
    .busy      (busy),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sst_ram #(
    .WIDTH(8),
    .DEPTH(3 * SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r  <= res.status;
      out_slot_r    <= res.slot;
      out_evicted_r <= res.evicted;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_evicted_sat = out_evicted_r;

endmodule

/* hw/rtl/sst_checker.sv */
module sst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_constellation,
  input logic       out_strobe,
  input logic [2:0] out_status,
  input logic [3:0] out_slot,
  input logic [7:0] out_evicted_sat
);

  import sst_pkg::*;

  // unsupported constellation answers on the next cycle
  a_bad_sys: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_constellation == SYS_UNSUP)
    |=> out_strobe && (out_status == ST_BAD_SYS))
    else $error("unsupported constellation not reported next cycle");

  // errors carry zero slot and zero evicted number
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ((out_status == ST_BAD_SYS) || (out_status == ST_UNKNOWN))
    |-> (out_slot == 4'd0) && (out_evicted_sat == 8'd0))
    else $error("error result with nonzero slot or evicted number");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_EVICT) |-> out_evicted_sat == 8'd0)
    else $error("evicted number without eviction");

  // busy only follows an accepted item and ends with its result
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without an item");

  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("item finished without a result");

endmodule

bind satellite_slot_table_core sst_checker u_sst_checker (.*);

/* bench/tb.sv */
module tb;
  import sst_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    status_t    status;
    logic [3:0] slot;
    logic [7:0] evicted;
  } slot_answer_t;

  class slot_ring_tracker;
    logic [7:0]   ring_sat [RINGS][SLOTS];
    int           ring_first [RINGS];
    int           ring_fill [RINGS];
    slot_answer_t awaited [$];
    int           mismatches;

    function new();
      for (int r = 0; r < RINGS; r++) begin
        ring_first[r] = 0;
        ring_fill[r] = 0;
      end
      mismatches = 0;
    endfunction

    // work out the answer to one accepted item and update the rings
    function void note_request(logic op, logic [1:0] sys, logic [7:0] sat);
      slot_answer_t a;
      int           ring;
      int           p;
      bit           hit;
      a.status = ST_FOUND;
      a.slot = '0;
      a.evicted = '0;
      hit = 1'b0;
      ring = int'(sys);
      if (sys == SYS_UNSUP) begin
        a.status = ST_BAD_SYS;
      end else begin
        for (int i = 0; i < ring_fill[ring] && !hit; i++) begin
          p = (ring_first[ring] + i) % SLOTS;
          if (ring_sat[ring][p] == sat) begin
            hit = 1'b1;
            a.slot = 4'(p);
          end
        end
        if (hit) begin
          a.status = ST_FOUND;
        end else if (op == OP_LOOKUP) begin
          a.status = ST_UNKNOWN;
        end else if (ring_fill[ring] < SLOTS) begin
          p = (ring_first[ring] + ring_fill[ring]) % SLOTS;
          ring_sat[ring][p] = sat;
          ring_fill[ring]++;
          a.status = ST_NEW;
          a.slot = 4'(p);
        end else begin
          p = ring_first[ring];
          a.evicted = ring_sat[ring][p];
          ring_sat[ring][p] = sat;
          ring_first[ring] = (p + 1) % SLOTS;
          a.status = ST_EVICT;
          a.slot = 4'(p);
        end
      end
      awaited.push_back(a);
    endfunction

    function void check_answer(logic [2:0] st, logic [3:0] sl, logic [7:0] ev);
      slot_answer_t a;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: status %0d slot %0d evicted %0d", st, sl, ev);
        return;
      end
      a = awaited[0];
      awaited.delete(0);
      if (st !== a.status || sl !== a.slot || ev !== a.evicted) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d slot %0d evicted %0d, got %0d %0d %0d",
                   a.status, a.slot, a.evicted, st, sl, ev);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_operation;
  logic [1:0] in_constellation;
  logic [7:0] in_sat_number;
  logic       out_strobe;
  logic [2:0] out_status;
  logic [3:0] out_slot;
  logic [7:0] out_evicted_sat;

  slot_ring_tracker tracker = new();
  int               idle_pct;
  int               cycle_cnt;
  logic [7:0]       sat_pool [RINGS][24];

  satellite_slot_table_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_constellation (in_constellation),
    .in_sat_number    (in_sat_number),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_evicted_sat  (out_evicted_sat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      tracker.note_request(in_operation, in_constellation, in_sat_number);
    if (rst_n && out_strobe)
      tracker.check_answer(out_status, out_slot, out_evicted_sat);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_request(input logic op, input logic [1:0] sys, input logic [7:0] sat);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_constellation <= sys;
    in_sat_number <= sat;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random(input int n);
    logic       op;
    logic [1:0] sys;
    logic [7:0] sat;
    for (int k = 0; k < n; k++) begin
      op = ($urandom_range(99) < 60) ? OP_ADD : OP_LOOKUP;
      sys = ($urandom_range(99) < 10) ? SYS_UNSUP : 2'($urandom_range(RINGS - 1));
      // mostly a small pool per ring so rings fill, hit and evict
      if ($urandom_range(99) < 75 && sys != SYS_UNSUP)
        sat = sat_pool[sys][$urandom_range(23)];
      else
        sat = 8'($urandom_range(255));
      send_request(op, sys, sat);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = 1'b0;
    in_constellation = '0;
    in_sat_number = '0;
    idle_pct = 0;
    for (int r = 0; r < RINGS; r++)
      for (int j = 0; j < 24; j++)
        sat_pool[r][j] = 8'($urandom_range(255));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty ring, unsupported system
    send_request(OP_LOOKUP, 2'd0, 8'd0);
    send_request(OP_ADD, SYS_UNSUP, 8'd255);
    send_request(OP_LOOKUP, SYS_UNSUP, 8'd0);
    // fill gps completely
    send_request(OP_ADD, 2'd0, 8'd255);
    send_request(OP_ADD, 2'd0, 8'd0);
    for (int s = 1; s <= SLOTS - 2; s++)
      send_request(OP_ADD, 2'd0, 8'(s));
    // full ring: evict oldest, then hits and a miss on the evicted one
    send_request(OP_ADD, 2'd0, 8'd200);
    send_request(OP_ADD, 2'd0, 8'd5);
    send_request(OP_LOOKUP, 2'd0, 8'd0);
    send_request(OP_LOOKUP, 2'd0, 8'd255);
    send_request(OP_ADD, 2'd1, 8'd255);
    send_request(OP_ADD, 2'd2, 8'd0);

    idle_pct = 0;
    send_random(200);
    idle_pct = 45;
    send_random(200);
    idle_pct = 6;
    send_random(200);

    @(negedge clk);
    start <= 1'b0;
    while (tracker.outstanding() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

/* satellite_slot_table_core.f */
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sst_ctrl.sv
hw/rtl/satellite_slot_table_core.sv
hw/rtl/sst_checker.sv
bench/tb.sv
